@@ design/rrur_pkg.sv @@
// Shared types and constants for the round-robin ultrasonic ranger.
`default_nettype none

package rrur_pkg;

  // Block geometry.
  localparam int NUM_SENSORS_DEF = 4;
  localparam int ECHO_LINES      = 4;

  // Field widths.
  localparam int TRIG_W   = 8;
  localparam int SLOT_W   = 20;
  localparam int SCALE_W  = 16;
  localparam int DIST_W   = 11;
  localparam int TIMER_W  = 16;
  localparam int INDEX_W  = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RECIP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID_CM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID_CM  = 3'd4;

  // Register values after reset.
  localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 8'd10;
  localparam logic [SLOT_W-1:0]  SLOT_TICKS_RST    = 20'd500000;
  localparam logic [SCALE_W-1:0] SCALE_RECIP_RST   = 16'd1114;
  localparam logic [DIST_W-1:0]  MIN_VALID_CM_RST  = 11'd2;
  localparam logic [DIST_W-1:0]  MAX_VALID_CM_RST  = 11'd400;

  // Stream widths.
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 2;

  // One tick's outcome from the slot sequencer, before distance scaling.
  typedef struct packed {
    logic [ECHO_LINES-1:0] trigger_lines;
    logic                  reading_done;
    logic [INDEX_W-1:0]    sensor_index;
    logic [TIMER_W-1:0]    echo_count;
  } tick_t;

endpackage

`default_nettype wire

@@ design/rrur_slot_ctrl.sv @@
// Slot sequencer: sensor rotation, trigger timing and echo timer.
`default_nettype none

module rrur_slot_ctrl #(
  parameter int NUM_SENSORS = rrur_pkg::NUM_SENSORS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire logic [rrur_pkg::ECHO_LINES-1:0]  echo_levels,
  input  wire logic [rrur_pkg::TRIG_W-1:0]      trigger_ticks,
  input  wire logic [rrur_pkg::SLOT_W-1:0]      slot_ticks,
  output rrur_pkg::tick_t                       tick
);

  localparam int SensW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam logic [SensW-1:0] LastSensor = SensW'(NUM_SENSORS - 1);
  localparam logic [rrur_pkg::TIMER_W-1:0] TimerMax = '1;

  logic [SensW-1:0]                 slot_sensor;
  logic [SensW-1:0]                 slot_sensor_next;
  logic [rrur_pkg::SLOT_W-1:0]      slot_counter;
  logic [rrur_pkg::SLOT_W-1:0]      slot_counter_next;
  logic [rrur_pkg::TIMER_W-1:0]     echo_counter;
  logic [rrur_pkg::TIMER_W-1:0]     echo_counter_next;
  logic                             counting;
  logic                             counting_next;
  logic                             prev_echo;
  logic                             prev_echo_next;

  logic [rrur_pkg::ECHO_LINES-1:0]  echo_shift;
  logic                             echo;
  logic [rrur_pkg::SLOT_W:0]        slot_inc;
  logic                             done;

  // A sensor past the physical lines shifts everything out: echo 0, no trigger.
  assign echo_shift = echo_levels >> slot_sensor;
  assign echo       = echo_shift[0];
  assign slot_inc   = {1'b0, slot_counter} + 1'b1;

  always_comb begin
    echo_counter_next = echo_counter;
    counting_next     = counting;
    prev_echo_next    = echo;
    done              = 1'b0;
    if (slot_counter == '0) begin
      echo_counter_next = '0;
      counting_next     = 1'b0;
    end else if (echo && !prev_echo) begin
      counting_next = 1'b1;
    end else if (!echo && prev_echo) begin
      counting_next = 1'b0;
      done          = 1'b1;
    end else if (counting && (echo_counter != TimerMax)) begin
      echo_counter_next = echo_counter + 1'b1;
    end

    if (slot_inc >= {1'b0, slot_ticks}) begin
      slot_counter_next = '0;
      slot_sensor_next  = (slot_sensor == LastSensor) ? '0 : slot_sensor + 1'b1;
    end else begin
      slot_counter_next = slot_inc[rrur_pkg::SLOT_W-1:0];
      slot_sensor_next  = slot_sensor;
    end
  end

  always_comb begin
    tick.trigger_lines = '0;
    if (slot_counter < {{(rrur_pkg::SLOT_W - rrur_pkg::TRIG_W){1'b0}}, trigger_ticks}) begin
      tick.trigger_lines = rrur_pkg::ECHO_LINES'(1) << slot_sensor;
    end
    tick.reading_done = done;
    tick.sensor_index = rrur_pkg::INDEX_W'(slot_sensor);
    tick.echo_count   = echo_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_sensor  <= '0;
      slot_counter <= '0;
      echo_counter <= '0;
      counting     <= 1'b0;
      prev_echo    <= 1'b0;
    end else if (step) begin
      slot_sensor  <= slot_sensor_next;
      slot_counter <= slot_counter_next;
      echo_counter <= echo_counter_next;
      counting     <= counting_next;
      prev_echo    <= prev_echo_next;
    end
  end

endmodule

`default_nettype wire

@@ design/round_robin_ultrasonic_ranger.sv @@
// Top level of the round-robin ultrasonic ranger: stream ports, registers, distance scaling.
//
//   channel | direction | payload
//   --------+-----------+------------------------------------------------------------
//   s_axis  | in        | tdata[3:0] echo_levels, one timer tick per item
//   m_axis  | out       | tdata: trigger_lines, sensor_index, distance_cm;
//           |           | tuser: reading_done, in_range
//   cfg     | in        | write enable, register index, write data
//
// One item is taken every cycle when the output side keeps up. An item's result
// is registered in the first stage when the item is accepted, then loaded into
// the output register, from which it can leave. The first stage runs the slot
// sequencer and the echo timer; the second multiplies the timer by scale_recip
// (one 16x16 multiplier) and checks the range. Reset clears the sequencer, the
// stage valids and the registers to their defaults. A stall on the output holds
// both stages, and the input is taken again as soon as a stage frees up.
`default_nettype none

module round_robin_ultrasonic_ranger #(
  parameter int NUM_SENSORS = rrur_pkg::NUM_SENSORS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [rrur_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [3:0] echo_levels
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [rrur_pkg::M_TDATA_W-1:0]         m_axis_tdata,  // [3:0] trigger_lines,
                                                                // [5:4] sensor_index,
                                                                // [16:6] distance_cm
  output logic [rrur_pkg::M_TUSER_W-1:0]         m_axis_tuser,  // [0] reading_done,
                                                                // [1] in_range
  // Configuration writes.
  input  wire logic                              cfg_we,
  input  wire logic [rrur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrur_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ProdW = rrur_pkg::TIMER_W + rrur_pkg::SCALE_W;
  localparam logic [rrur_pkg::SCALE_W-1:0] DistCap =
    rrur_pkg::SCALE_W'((1 << rrur_pkg::DIST_W) - 1);

  // Configuration registers.
  logic [rrur_pkg::TRIG_W-1:0]   trigger_ticks;
  logic [rrur_pkg::SLOT_W-1:0]   slot_ticks;
  logic [rrur_pkg::SCALE_W-1:0]  scale_recip;
  logic [rrur_pkg::DIST_W-1:0]   min_valid_cm;
  logic [rrur_pkg::DIST_W-1:0]   max_valid_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= rrur_pkg::TRIGGER_TICKS_RST;
      slot_ticks    <= rrur_pkg::SLOT_TICKS_RST;
      scale_recip   <= rrur_pkg::SCALE_RECIP_RST;
      min_valid_cm  <= rrur_pkg::MIN_VALID_CM_RST;
      max_valid_cm  <= rrur_pkg::MAX_VALID_CM_RST;
    end else if (cfg_we) begin
      // Indexes past the last register are dropped by the default arm.
      unique case (cfg_index)
        rrur_pkg::REG_TRIGGER_TICKS: trigger_ticks <= cfg_data[rrur_pkg::TRIG_W-1:0];
        rrur_pkg::REG_SLOT_TICKS:    slot_ticks    <= cfg_data[rrur_pkg::SLOT_W-1:0];
        rrur_pkg::REG_SCALE_RECIP:   scale_recip   <= cfg_data[rrur_pkg::SCALE_W-1:0];
        rrur_pkg::REG_MIN_VALID_CM:  min_valid_cm  <= cfg_data[rrur_pkg::DIST_W-1:0];
        rrur_pkg::REG_MAX_VALID_CM:  max_valid_cm  <= cfg_data[rrur_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the first stage moves when the output register can take its item.
  logic a_valid;
  logic a_ready;
  logic in_accept;

  assign a_ready       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !a_valid || a_ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Stage one: the sequencer state advances exactly once per accepted tick.
  rrur_pkg::tick_t tick;
  rrur_pkg::tick_t a_tick;

  rrur_slot_ctrl #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_slot_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (in_accept),
    .echo_levels   (s_axis_tdata[rrur_pkg::ECHO_LINES-1:0]),
    .trigger_ticks (trigger_ticks),
    .slot_ticks    (slot_ticks),
    .tick          (tick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_tick <= tick;
    end
  end

  // Stage two: distance = (timer * scale_recip) >> 16. The range check looks at
  // the full quotient; the reported value clips at the top of its field.
  logic [ProdW-1:0]              product;
  logic [rrur_pkg::SCALE_W-1:0]  dist_full;
  logic [rrur_pkg::DIST_W-1:0]   dist_clip;
  logic                          dist_ok;
  logic [rrur_pkg::DIST_W-1:0]   distance_cm;
  logic                          in_range;

  assign product   = ProdW'(a_tick.echo_count) * ProdW'(scale_recip);
  assign dist_full = product[ProdW-1:rrur_pkg::TIMER_W];
  assign dist_clip = (dist_full > DistCap) ? DistCap[rrur_pkg::DIST_W-1:0]
                                           : dist_full[rrur_pkg::DIST_W-1:0];
  assign dist_ok   = (dist_full >= rrur_pkg::SCALE_W'(min_valid_cm)) &&
                     (dist_full <= rrur_pkg::SCALE_W'(max_valid_cm));
  // Without a completed reading both fields read as zero.
  assign distance_cm = a_tick.reading_done ? dist_clip : '0;
  assign in_range    = a_tick.reading_done && dist_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (a_ready) begin
      m_axis_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      m_axis_tdata <= {{(rrur_pkg::M_TDATA_W - rrur_pkg::DIST_W - rrur_pkg::INDEX_W
                         - rrur_pkg::ECHO_LINES){1'b0}},
                       distance_cm, a_tick.sensor_index, a_tick.trigger_lines};
      m_axis_tuser <= {in_range, a_tick.reading_done};
    end
  end

`ifndef SYNTHESIS
  // At most one trigger line is ever driven.
  a_trig_onehot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[3:0]))
    else $error("more than one trigger line high");

  // Distance and range flag stay zero unless a reading completed.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[16:6] == '0 && !m_axis_tuser[1]))
    else $error("distance reported without a completed reading");

  // A stalled first stage keeps its item for the output register.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_ready) |=> (a_valid && $stable(a_tick)))
    else $error("first stage lost its item under stall");

  // Nothing is in flight right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!a_valid && !m_axis_tvalid))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
